// ===== src/sact_pkg.sv =====
// Shared definitions for the set-associative cache tag unit.
// Holds default geometry, fixed port widths, the result word type and a saturating increment.
`default_nettype none

package sact_pkg;

  // Default geometry
  localparam int DEF_WAYS       = 4;
  localparam int DEF_SETS       = 128;
  localparam int DEF_LINE_BYTES = 32;

  // Fixed widths of the access and result words
  localparam int ADDR_W    = 32;
  localparam int CNT_W     = 32;
  localparam int WAY_OUT_W = 2;

  // One result word as sent to the port
  typedef struct packed {
    logic                 hit;
    logic                 allocated;
    logic [WAY_OUT_W-1:0] way_used;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     access_total;
  } sact_result_t;

  // Saturating increment of a running count
  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

`default_nettype wire

// ===== src/sact_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module sact_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                 clk,
  input  wire logic                                 we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                     wdata,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== src/sact_front.sv =====
// Front end of the cache tag unit: takes accesses, splits the address into
// set index and tag, and holds them in a two-entry queue for the back end.
// Depends on sact_pkg.
`default_nettype none

module sact_front
  import sact_pkg::*;
#(
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic              store_op,
  input  wire logic              clearing,
  output logic                   busy,
  output logic                   q_valid,
  input  wire logic              q_pop,
  output logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] q_set,
  output logic [ADDR_W-$clog2(LINE_BYTES)-$clog2(SETS)-1:0] q_tag,
  output logic                   q_store
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(SETS);
  localparam int SET_AW = (IDX_W > 0) ? IDX_W : 1;
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
  localparam int PW     = SET_AW + TAG_W + 1;
  localparam logic [ADDR_W-1:0] IDX_MASK = ADDR_W'((64'd1 << IDX_W) - 64'd1);

  logic [PW-1:0]     slot [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              push;
  logic [SET_AW-1:0] set_idx;
  logic [TAG_W-1:0]  tag;

  // Split the address
  assign set_idx = SET_AW'((address >> OFF_W) & IDX_MASK);
  assign tag     = TAG_W'(address >> (OFF_W + IDX_W));

  // Accept when the queue has room and the back end is not clearing
  assign busy = clearing || (count == 2'd2);
  assign push = start && !busy;

  // Queue head
  assign q_valid                 = (count != 2'd0);
  assign {q_set, q_tag, q_store} = slot[rd_ptr];

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (q_pop) begin
        rd_ptr <= !rd_ptr;
      end
      count <= count + 2'(push) - 2'(q_pop);
    end
  end

  // Hold queued words
  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= {set_idx, tag, store_op};
    end
  end

  // An accepted word is always waiting in the next cycle
  a_push_lands: assert property (@(posedge clk) disable iff (rst)
    push |=> q_valid)
    else $error("accepted word not queued");

  // Never pop an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> count != 2'd0)
    else $error("pop from empty queue");

endmodule

`default_nettype wire

// ===== src/sact_back.sv =====
// Back end of the cache tag unit: reads a set, matches tags, picks the LRU
// victim, writes the set back and registers the result word.
// Depends on sact_pkg and sact_ram.
`default_nettype none

module sact_back
  import sact_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              write_allocate,
  input  wire logic              q_valid,
  output logic                   q_pop,
  input  wire logic [(SETS > 1 ? $clog2(SETS) : 1)-1:0] q_set,
  input  wire logic [ADDR_W-$clog2(LINE_BYTES)-$clog2(SETS)-1:0] q_tag,
  input  wire logic              q_store,
  output logic                   clearing,
  output logic                   done,
  output sact_result_t           res
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(SETS);
  localparam int SET_AW = (IDX_W > 0) ? IDX_W : 1;
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;
  localparam int ROWS   = 1 << IDX_W;
  localparam int RANK_W = $clog2(WAYS);
  localparam int WAY_W  = RANK_W;
  localparam int MW     = 1 + RANK_W;

  typedef enum logic [1:0] {S_CLEAR, S_READ, S_LOOK} state_t;

  state_t                 state;
  logic [SET_AW-1:0]      clr_cnt;
  logic [SET_AW-1:0]      cur_set;
  logic [TAG_W-1:0]       cur_tag;
  logic                   cur_store;

  logic                   tag_we;
  logic [WAYS*TAG_W-1:0]  tag_rdata;
  logic [WAYS*TAG_W-1:0]  tag_new;
  logic                   meta_we;
  logic [SET_AW-1:0]      meta_waddr;
  logic [WAYS*MW-1:0]     meta_wdata;
  logic [WAYS*MW-1:0]     meta_rdata;
  logic [WAYS*MW-1:0]     meta_new;
  logic [WAYS*MW-1:0]     reset_row;

  logic [RANK_W-1:0]      rank_q [WAYS];
  logic                   valid_q [WAYS];
  logic                   hit;
  logic [WAY_W-1:0]       hit_way;
  logic                   found_v;
  logic [WAY_W-1:0]       victim;
  logic                   do_alloc;
  logic                   upd;
  logic [WAY_W-1:0]       used;
  logic [RANK_W-1:0]      old_rank;

  // Tag rows and valid/rank rows, one row per set
  sact_ram #(.WIDTH(WAYS*TAG_W), .DEPTH(ROWS)) u_tag_ram (
    .clk   (clk),
    .we    (tag_we),
    .waddr (cur_set),
    .wdata (tag_new),
    .raddr (q_set),
    .rdata (tag_rdata)
  );

  sact_ram #(.WIDTH(WAYS*MW), .DEPTH(ROWS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (q_set),
    .rdata (meta_rdata)
  );

  // Row after reset: all invalid, way w at rank WAYS-1-w
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      reset_row[w*MW +: MW] = {1'b0, RANK_W'(WAYS - 1 - w)};
    end
  end

  // Unpack the set's valid bits and ranks
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      valid_q[w] = meta_rdata[w*MW + RANK_W];
      rank_q[w]  = meta_rdata[w*MW +: RANK_W];
    end
  end

  // Match tags and find the least recent way, lowest way first
  always_comb begin
    hit     = 1'b0;
    hit_way = '0;
    found_v = 1'b0;
    victim  = '0;
    for (int w = 0; w < WAYS; w++) begin
      if (!hit && valid_q[w] && (tag_rdata[w*TAG_W +: TAG_W] == cur_tag)) begin
        hit     = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!found_v && (rank_q[w] == RANK_W'(WAYS - 1))) begin
        found_v = 1'b1;
        victim  = WAY_W'(w);
      end
    end
  end

  assign do_alloc = !hit && (!cur_store || write_allocate);
  assign upd      = hit || do_alloc;
  assign used     = hit ? hit_way : victim;
  assign old_rank = rank_q[used];

  // Make the used way most recent and age the ways more recent than it
  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      if (WAY_W'(w) == used) begin
        meta_new[w*MW +: MW] = {valid_q[w] | do_alloc, {RANK_W{1'b0}}};
        tag_new[w*TAG_W +: TAG_W] = do_alloc ? cur_tag : tag_rdata[w*TAG_W +: TAG_W];
      end else begin
        meta_new[w*MW +: MW] = {valid_q[w],
          (rank_q[w] < old_rank) ? RANK_W'(rank_q[w] + 1'b1) : rank_q[w]};
        tag_new[w*TAG_W +: TAG_W] = tag_rdata[w*TAG_W +: TAG_W];
      end
    end
  end

  // Write ports: clearing sweep, then set write-back
  always_comb begin
    meta_we    = 1'b0;
    meta_waddr = cur_set;
    meta_wdata = meta_new;
    tag_we     = 1'b0;
    case (state)
      S_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_cnt;
        meta_wdata = reset_row;
      end
      S_LOOK: begin
        meta_we = upd;
        tag_we  = do_alloc;
      end
      default: begin
        meta_we = 1'b0;
      end
    endcase
  end

  assign q_pop    = (state == S_READ) && q_valid;
  assign clearing = (state == S_CLEAR);

  // Sequence: clear rows, read a set, look up and write back
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_CLEAR;
      clr_cnt          <= '0;
      done             <= 1'b0;
      res.hit_total    <= '0;
      res.access_total <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == SET_AW'(ROWS - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          if (q_valid) begin
            cur_set   <= q_set;
            cur_tag   <= q_tag;
            cur_store <= q_store;
            state     <= S_LOOK;
          end
        end
        S_LOOK: begin
          done             <= 1'b1;
          res.hit          <= hit;
          res.allocated    <= do_alloc;
          res.way_used     <= upd ? WAY_OUT_W'(used) : '0;
          res.hit_total    <= hit ? sat_inc(res.hit_total) : res.hit_total;
          res.access_total <= sat_inc(res.access_total);
          state            <= S_READ;
        end
        default: begin
          state <= S_READ;
        end
      endcase
    end
  end

  // A result never both hits and refills
  a_hit_xor_alloc: assert property (@(posedge clk) disable iff (rst)
    done |-> !(res.hit && res.allocated))
    else $error("hit and allocate in one word");

  // Hits never outrun accesses
  a_counts: assert property (@(posedge clk) disable iff (rst)
    res.hit_total <= res.access_total)
    else $error("hit count above access count");

  // A result follows a lookup cycle
  a_done_after_look: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state) == S_LOOK)
    else $error("result word without lookup");

endmodule

`default_nettype wire

// ===== src/set_assoc_lru_cache_tags_unit.sv =====
// Top level of the set-associative cache tag unit with true LRU replacement.
// done rises once the back end has read the set row and looked it up, plus any
// queue wait; the two-entry queue takes new accesses meanwhile. The receiver
// cannot stall; done lasts one cycle. Reset (rst, synchronous) clears the
// counters and sweeps the valid/rank rows, one set per cycle; busy stays high
// until all 2^ceil(log2(SETS)) rows are swept.
`default_nettype none

module set_assoc_lru_cache_tags_unit
  import sact_pkg::*;
#(
  parameter int WAYS       = DEF_WAYS,
  parameter int SETS       = DEF_SETS,
  parameter int LINE_BYTES = DEF_LINE_BYTES
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  output logic                      busy,
  input  wire logic [ADDR_W-1:0]    address,
  input  wire logic                 store_op,
  output logic                      done,
  output logic                      hit,
  output logic                      allocated,
  output logic [WAY_OUT_W-1:0]      way_used,
  output logic [CNT_W-1:0]          hit_total,
  output logic [CNT_W-1:0]          access_total,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic                 cfg_data
);

  localparam int OFF_W  = $clog2(LINE_BYTES);
  localparam int IDX_W  = $clog2(SETS);
  localparam int SET_AW = (IDX_W > 0) ? IDX_W : 1;
  localparam int TAG_W  = ADDR_W - OFF_W - IDX_W;

  logic              write_allocate;
  logic              q_valid;
  logic              q_pop;
  logic [SET_AW-1:0] q_set;
  logic [TAG_W-1:0]  q_tag;
  logic              q_store;
  logic              clearing;
  sact_result_t      res;

  // Write-allocate register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      write_allocate <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      write_allocate <= cfg_data;
    end
  end

  sact_front #(.SETS(SETS), .LINE_BYTES(LINE_BYTES)) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .address  (address),
    .store_op (store_op),
    .clearing (clearing),
    .busy     (busy),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_set    (q_set),
    .q_tag    (q_tag),
    .q_store  (q_store)
  );

  sact_back #(.WAYS(WAYS), .SETS(SETS), .LINE_BYTES(LINE_BYTES)) u_back (
    .clk            (clk),
    .rst            (rst),
    .write_allocate (write_allocate),
    .q_valid        (q_valid),
    .q_pop          (q_pop),
    .q_set          (q_set),
    .q_tag          (q_tag),
    .q_store        (q_store),
    .clearing       (clearing),
    .done           (done),
    .res            (res)
  );

  // Drive the result word onto its ports
  assign hit          = res.hit;
  assign allocated    = res.allocated;
  assign way_used     = res.way_used;
  assign hit_total    = res.hit_total;
  assign access_total = res.access_total;

endmodule

`default_nettype wire

// ===== bench/sact_checker.sv =====
// Checker for the cache tag unit: watches the access, result and config channels.
// Keeps its own tag/valid/rank model, compares every result word; needs sact_pkg.
`timescale 1ns / 100ps

module sact_checker
  import sact_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [ADDR_W-1:0] address,
  input  logic              store_op,
  input  logic              cfg_valid,
  input  logic              cfg_ready,
  input  logic              cfg_data,
  input  logic              done,
  input  logic              hit,
  input  logic              allocated,
  input  logic [WAY_OUT_W-1:0] way_used,
  input  logic [CNT_W-1:0]  hit_total,
  input  logic [CNT_W-1:0]  access_total,
  output int                errors,
  output int                outstanding
);

  localparam int OFF_W   = $clog2(DEF_LINE_BYTES);
  localparam int IDX_W   = $clog2(DEF_SETS);
  localparam int TAG_W   = ADDR_W - OFF_W - IDX_W;
  localparam int ROWS    = 1 << IDX_W;
  localparam int RANK_W  = $clog2(DEF_WAYS);
  localparam int LRU_RANK = DEF_WAYS - 1;

  // Shadow copy of the tag store and the replacement state
  logic [TAG_W-1:0]  tag_mem   [ROWS][DEF_WAYS];
  logic              line_vld  [ROWS][DEF_WAYS];
  logic [RANK_W-1:0] rank_mem  [ROWS][DEF_WAYS];
  logic [CNT_W-1:0]  hits_seen;
  logic [CNT_W-1:0]  accesses_seen;
  logic              alloc_on_store;

  sact_result_t      lookup_q[$];
  int                err_cnt = 0;

  // Promote one way of a row to most recent, aging the younger ones
  function automatic void touch_way(input int row, input int way);
    logic [RANK_W-1:0] old;
    old = rank_mem[row][way];
    for (int w = 0; w < DEF_WAYS; w++) begin
      if (rank_mem[row][w] < old) rank_mem[row][w] = rank_mem[row][w] + 1'b1;
    end
    rank_mem[row][way] = '0;
  endfunction

  // Look up one access, update the shadow state and return the result word
  function automatic sact_result_t lookup_access(input logic [ADDR_W-1:0] addr,
                                                 input logic st);
    sact_result_t     res;
    int               row;
    int               way;
    logic [TAG_W-1:0] tag;
    logic             found;
    row   = int'(addr[OFF_W +: IDX_W]);
    tag   = addr[ADDR_W-1 -: TAG_W];
    found = 1'b0;
    way   = 0;
    res   = '0;
    for (int w = 0; w < DEF_WAYS; w++) begin
      if (!found && line_vld[row][w] && tag_mem[row][w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      touch_way(row, way);
      hits_seen = sat_inc(hits_seen);
      res.hit   = 1'b1;
      res.way_used = WAY_OUT_W'(way);
    end else if (!st || alloc_on_store) begin
      // Refill the least recent way
      for (int w = DEF_WAYS - 1; w >= 0; w--) begin
        if (rank_mem[row][w] == RANK_W'(LRU_RANK)) way = w;
      end
      touch_way(row, way);
      tag_mem[row][way]  = tag;
      line_vld[row][way] = 1'b1;
      res.allocated      = 1'b1;
      res.way_used       = WAY_OUT_W'(way);
    end
    accesses_seen    = sat_inc(accesses_seen);
    res.hit_total    = hits_seen;
    res.access_total = accesses_seen;
    return res;
  endfunction

  function automatic void report_field(input string name, input logic [CNT_W-1:0] exp_v,
                                       input logic [CNT_W-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_v, got_v);
      err_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    sact_result_t want;
    if (rst) begin
      for (int r = 0; r < ROWS; r++) begin
        for (int w = 0; w < DEF_WAYS; w++) begin
          tag_mem[r][w]  = '0;
          line_vld[r][w] = 1'b0;
          rank_mem[r][w] = RANK_W'(DEF_WAYS - 1 - w);
        end
      end
      hits_seen      = '0;
      accesses_seen  = '0;
      alloc_on_store = 1'b1;
      lookup_q.delete();
    end else begin
      // Compare a result word against the oldest prediction
      if (done) begin
        if (lookup_q.size() == 0) begin
          $display("%0t: result word with nothing expected, got hit=%0b alloc=%0b way=%0d",
                   $time, hit, allocated, way_used);
          err_cnt++;
        end else begin
          want = lookup_q.pop_front();
          report_field("hit", CNT_W'(want.hit), CNT_W'(hit));
          report_field("allocated", CNT_W'(want.allocated), CNT_W'(allocated));
          report_field("way_used", CNT_W'(want.way_used), CNT_W'(way_used));
          report_field("hit_total", want.hit_total, hit_total);
          report_field("access_total", want.access_total, access_total);
        end
      end
      // Track the write-allocate register
      if (cfg_valid && cfg_ready) alloc_on_store = cfg_data;
      // Predict each accepted access word
      if (start && !busy) lookup_q = {lookup_q, lookup_access(address, store_op)};
    end
    errors      <= err_cnt;
    outstanding <= lookup_q.size();
  end

endmodule

// ===== bench/testbench.sv =====
// Top of the cache tag unit bench: clock, reset, access and config stimulus, verdict.
// Depends on sact_pkg, set_assoc_lru_cache_tags_unit and sact_checker.
`timescale 1ns / 100ps

module testbench;
  import sact_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 100;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic                 busy;
  logic [ADDR_W-1:0]    address = '0;
  logic                 store_op = 1'b0;
  logic                 done;
  logic                 hit;
  logic                 allocated;
  logic [WAY_OUT_W-1:0] way_used;
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     access_total;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic                 cfg_data = 1'b0;
  int                   errors;
  int                   outstanding;
  int                   cycles = 0;
  logic                 no_gaps = 1'b0;

  always #10 clk = ~clk;

  set_assoc_lru_cache_tags_unit u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .address(address),
    .store_op(store_op), .done(done), .hit(hit), .allocated(allocated),
    .way_used(way_used), .hit_total(hit_total), .access_total(access_total),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  sact_checker u_check (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .address(address),
    .store_op(store_op), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_data(cfg_data), .done(done), .hit(hit), .allocated(allocated),
    .way_used(way_used), .hit_total(hit_total), .access_total(access_total),
    .errors(errors), .outstanding(outstanding)
  );

  // Abort a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  function automatic logic [ADDR_W-1:0] line_addr(input logic [19:0] tag,
                                                  input logic [6:0] row,
                                                  input logic [4:0] off);
    return {tag, row, off};
  endfunction

  // Present one access word and hold it until taken; start stays high
  task automatic send_access(input logic [ADDR_W-1:0] addr, input logic st);
    start    <= 1'b1;
    address  <= addr;
    store_op <= st;
    do @(posedge clk); while (busy);
  endtask

  // Drop start for a random gap: mostly short, sometimes long
  task automatic idle_gap();
    int pick;
    int len;
    pick = $urandom_range(0, 99);
    if (no_gaps || pick < 45) len = 0;
    else if (pick < 85) len = $urandom_range(1, 3);
    else if (pick < 97) len = $urandom_range(4, 12);
    else len = $urandom_range(20, 60);
    if (len > 0) begin
      start   <= 1'b0;
      address <= $urandom;
      repeat (len) @(posedge clk);
    end
  endtask

  // Drain all results, then write the write-allocate register
  task automatic set_write_alloc(input logic value);
    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    repeat ($urandom_range(0, 3)) @(posedge clk);
  endtask

  initial begin
    logic [19:0] tag_pool [6];
    logic [6:0]  hot_rows [4];
    logic [ADDR_W-1:0] addr;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed: extremes, hit, fill, eviction, store paths
    send_access(line_addr(20'h0, 7'd0, 5'd0), 1'b0);
    send_access(line_addr(20'h0, 7'd0, 5'd31), 1'b0);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b1);
    send_access(line_addr(20'h1, 7'd0, 5'd4), 1'b0);
    send_access(line_addr(20'h2, 7'd0, 5'd8), 1'b0);
    idle_gap();
    send_access(line_addr(20'h3, 7'd0, 5'd0), 1'b0);
    send_access(line_addr(20'h4, 7'd0, 5'd0), 1'b0);
    send_access(line_addr(20'h1, 7'd0, 5'd0), 1'b0);
    send_access(line_addr(20'h0, 7'd0, 5'd0), 1'b1);
    send_access(line_addr(20'hABCDE, 7'd5, 5'd0), 1'b1);
    set_write_alloc(1'b0);
    send_access(line_addr(20'h12345, 7'd6, 5'd7), 1'b1);
    send_access(line_addr(20'h12345, 7'd6, 5'd7), 1'b0);
    send_access(line_addr(20'h12345, 7'd6, 5'd9), 1'b1);
    send_access(line_addr(20'h55555, 7'd127, 5'd3), 1'b1);
    send_access(line_addr(20'h55555, 7'd127, 5'd3), 1'b1);
    send_access(line_addr(20'hFFFFF, 7'd127, 5'd31), 1'b0);
    set_write_alloc(1'b1);

    // Random phases, alternating write-allocate, on a few hot rows
    for (int phase = 0; phase < 4; phase++) begin
      for (int t = 0; t < 6; t++) tag_pool[t] = 20'($urandom);
      for (int r = 0; r < 4; r++) hot_rows[r] = 7'($urandom);
      if (phase == 1) hot_rows[0] = 7'd0;
      if (phase == 2) hot_rows[0] = 7'd127;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) != 0)
          addr = line_addr(tag_pool[$urandom_range(0, 5)], hot_rows[$urandom_range(0, 3)],
                           5'($urandom));
        else
          addr = $urandom;
        send_access(addr, 1'($urandom));
        idle_gap();
        // Hold off until the unit has answered everything
        if (phase == 1 && n == PHASE_ITEMS / 2) begin
          start <= 1'b0;
          do @(posedge clk); while (outstanding != 0);
        end
      end
      set_write_alloc(phase % 2 == 0 ? 1'b0 : 1'b1);
    end

    start <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
src/sact_pkg.sv
src/sact_ram.sv
src/sact_front.sv
src/sact_back.sv
src/set_assoc_lru_cache_tags_unit.sv
bench/sact_checker.sv
bench/testbench.sv
